/* sv/eigenvalue_metropolis_update_assert.svh */
// Assertion macros shared by the eigenvalue Metropolis update RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef EIGENVALUE_METROPOLIS_UPDATE_ASSERT_SVH
`define EIGENVALUE_METROPOLIS_UPDATE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EMU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define EMU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/emu_pkg.sv */
// Package for the eigenvalue Metropolis update block: widths, codes,
// sine coefficients, angle folding helpers and unit response structs. No dependencies.
package emu_pkg;

    localparam int MAX_SITES = 64;
    localparam int ADDR_W    = $clog2(MAX_SITES);
    localparam int CNT_W     = $clog2(MAX_SITES + 1);
    localparam int ANG_W     = 16;
    localparam int T_W       = 17;
    localparam int SIN_W     = 31;
    localparam int LN_W      = 24;
    localparam int COS_W     = 18;
    localparam int CS_W      = COS_W + CNT_W + 1;
    localparam int CSUM_W    = 24;
    localparam int CPL_W     = 14;
    localparam int SC_W      = 7;
    localparam int K_W       = CPL_W + CNT_W;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SITES     = 2'd2;

    // Item kinds.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Odd sine polynomial in Q30.
    localparam logic signed [33:0] SC1 = 34'sd1686629713;
    localparam logic signed [33:0] SC3 = -34'sd693598670;
    localparam logic signed [33:0] SC5 = 34'sd85569306;
    localparam logic signed [33:0] SC7 = -34'sd5026995;
    localparam logic signed [33:0] SC9 = 34'sd172273;

    localparam logic [SIN_W-1:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic             done;
        logic [SIN_W-1:0] value;
    } sin_rsp_t;

    typedef struct packed {
        logic                   done;
        logic signed [LN_W-1:0] value;
    } ln_rsp_t;

    // Horner coefficient for step k, highest order first after SC9.
    function automatic logic signed [33:0] sin_coef(input logic [1:0] k);
        logic signed [33:0] c;
        case (k)
            2'd0:    c = SC7;
            2'd1:    c = SC5;
            2'd2:    c = SC3;
            default: c = SC1;
        endcase
        return c;
    endfunction

    // Sine argument for |sin((a - b)/2)|: the shorter way round.
    function automatic logic [T_W-1:0] pair_fold(input logic [ANG_W-1:0] a,
                                                 input logic [ANG_W-1:0] b);
        logic [ANG_W-1:0] d;
        d = a - b;
        return (d <= 16'h8000) ? {1'b0, d} : (17'h10000 - {1'b0, d});
    endfunction

    // Sine argument for cos(a) after quadrant folding.
    function automatic logic [T_W-1:0] cos_fold(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] x;
        logic [14:0]      m;
        x = a + 16'h4000;
        m = x[14] ? (15'd16384 - {1'b0, x[13:0]}) : {1'b0, x[13:0]};
        return {1'b0, m, 1'b0};
    endfunction

    // Cosine is negative in the second half of the folded turn.
    function automatic logic cos_neg(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] x;
        x = a + 16'h4000;
        return x[15];
    endfunction

endpackage

/* sv/emu_sin.sv */
// Iterative sine unit: degree-9 odd polynomial by Horner over one multiplier.
// Depends on emu_pkg.
module emu_sin
    import emu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [T_W-1:0] t,
    output sin_rsp_t       rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQ   = 4'b0010,
        S_POLY = 4'b0100,
        S_FIN  = 4'b1000
    } sin_state_t;

    sin_state_t         state_reg, state_next;
    logic [T_W-1:0]     t_reg, t_next;
    logic [T_W-1:0]     t2_reg, t2_next;
    logic signed [33:0] p_reg, p_next;
    logic [1:0]         k_reg, k_next;
    logic               done_reg, done_next;
    logic [SIN_W-1:0]   res_reg, res_next;

    logic signed [34:0] op_a;
    logic signed [17:0] op_b;
    logic signed [52:0] prod;
    logic signed [52:0] prod_sh;

    // Shared multiplier, operands chosen by the step.
    always_comb
    begin
        op_a = 35'(p_reg);
        op_b = 18'($signed({1'b0, t2_reg}));
        case (state_reg)
            S_SQ:
            begin
                op_a = 35'($signed({1'b0, t_reg}));
                op_b = 18'($signed({1'b0, t_reg}));
            end
            S_FIN:
            begin
                op_b = 18'($signed({1'b0, t_reg}));
            end
            default:
            begin
                op_a = 35'(p_reg);
            end
        endcase
        prod    = 53'(op_a) * 53'(op_b);
        prod_sh = prod >>> 15;
    end

    // Step sequencer.
    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        t2_next    = t2_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    t_next     = t;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                t2_next    = prod[31:15];
                p_next     = SC9;
                k_next     = 2'd0;
                state_next = S_POLY;
            end
            S_POLY:
            begin
                p_next = sin_coef(k_reg) + 34'(prod_sh);
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Clamp to [0, 1.0] in Q30.
                if (prod_sh < 0)
                begin
                    res_next = '0;
                end
                else if (prod_sh > 53'($signed({1'b0, ONE_Q30})))
                begin
                    res_next = ONE_Q30;
                end
                else
                begin
                    res_next = prod_sh[SIN_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        t2_reg  <= t2_next;
        p_reg   <= p_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

/* sv/emu_ln.sv */
// Iterative natural log unit: bit-serial normalize, 16 squaring steps, scale by ln 2.
// Depends on emu_pkg.
module emu_ln
    import emu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SIN_W-1:0] v,
    output ln_rsp_t          rsp
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_SQ   = 4'b0100,
        L_FIN  = 4'b1000
    } ln_state_t;

    localparam logic signed [17:0] LN2_Q16 = 18'sd45426;

    ln_state_t             state_reg, state_next;
    logic [SIN_W-1:0]      m_reg, m_next;
    logic [4:0]            e_reg, e_next;
    logic [15:0]           frac_reg, frac_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic signed [LN_W-1:0] res_reg, res_next;

    logic [61:0]        sq;
    logic [31:0]        sq_sh;
    logic signed [5:0]  e_off;
    logic signed [21:0] log2_val;
    logic signed [39:0] scaled;

    always_comb
    begin
        sq       = 62'(m_reg) * 62'(m_reg);
        sq_sh    = sq[61:30];
        e_off    = $signed({1'b0, e_reg}) - 6'sd30;
        log2_val = $signed({e_off, frac_reg});
        scaled   = 40'(log2_val) * 40'(LN2_Q16);
    end

    // Step sequencer.
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    m_next     = v;
                    e_next     = 5'd30;
                    frac_next  = '0;
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                // One bit of the leading-one search per cycle.
                if (m_reg[SIN_W-1] || e_reg == 5'd0)
                begin
                    cnt_next   = '0;
                    state_next = L_SQ;
                end
                else
                begin
                    m_next = {m_reg[SIN_W-2:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            L_SQ:
            begin
                if (sq_sh[31])
                begin
                    m_next    = sq_sh[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_sh[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:
            begin
                res_next   = LN_W'(scaled >>> 16);
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

/* sv/eigenvalue_metropolis_update.sv */
// Top level of the eigenvalue Metropolis update: angle store, sequencer, result register.
// Depends on emu_pkg, emu_sin, emu_ln and eigenvalue_metropolis_update_assert.svh.
//
//  Channel  Signals                                     Direction  Carries
//  s_axis   tvalid tready tdata[55:0] tuser[0]          in         one load or update item
//  m_axis   tvalid tready tdata[47:0]                   out        one result per item
//  cfg      cfg_valid cfg_ready cfg_index cfg_data      in         register writes
//
// A load stores its angle, then sums the cosines of the angles in use.
// An update runs the sine and log units for each other angle in use, which one
// sequencer drives one at a time, and then the cosine sum.
// The input side is busy from a transaction until its result is registered.
// A result waits in the output register; the next item is taken meanwhile.
// Reset clears the configuration to its defaults and marks every stored angle zero.
`include "eigenvalue_metropolis_update_assert.svh"

module eigenvalue_metropolis_update
    import emu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // site, load_angle, step_fraction, accept_draw
    input  logic [0:0]           s_axis_tuser,  // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,  // accepted, site_angle, cosine_sum
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [22:0] {
        ST_IDLE     = 23'h000001,
        ST_LOAD     = 23'h000002,
        ST_OLD_RD   = 23'h000004,
        ST_OLD_WAIT = 23'h000008,
        ST_PR_RD    = 23'h000010,
        ST_PR_GET   = 23'h000020,
        ST_PN_SIN   = 23'h000040,
        ST_PN_LN    = 23'h000080,
        ST_PO_START = 23'h000100,
        ST_PO_SIN   = 23'h000200,
        ST_PO_LN    = 23'h000400,
        ST_PR_DONE  = 23'h000800,
        ST_CN_SIN   = 23'h001000,
        ST_CO_SIN   = 23'h002000,
        ST_MUL1     = 23'h004000,
        ST_MUL2     = 23'h008000,
        ST_DS       = 23'h010000,
        ST_ULN      = 23'h020000,
        ST_COMMIT   = 23'h040000,
        ST_CS_RD    = 23'h080000,
        ST_CS_GET   = 23'h100000,
        ST_CS_SIN   = 23'h200000,
        ST_DONE     = 23'h400000
    } emu_state_t;

    // Cosine in Q16 from the Q30 sine magnitude, rounded before the sign.
    function automatic logic signed [COS_W-1:0] cos_round(input logic [SIN_W-1:0] s,
                                                          input logic neg);
        logic [31:0]      r;
        logic [COS_W-1:0] mag;
        r   = 32'(s) + 32'd8192;
        mag = r[31:14];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Configuration.
    logic [CPL_W-1:0] coupling_reg;
    logic [ANG_W-1:0] step_reg;
    logic [SC_W-1:0]  sites_reg;

    // Sequencer state.
    emu_state_t          state_reg, state_next;
    logic                op_reg, op_next;
    logic [5:0]          site_reg, site_next;
    logic [ANG_W-1:0]    load_reg, load_next;
    logic [ANG_W-1:0]    sf_reg, sf_next;
    logic [ANG_W-1:0]    draw_reg, draw_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [ANG_W-1:0]    old_reg, old_next;
    logic [ANG_W-1:0]    nw_reg, nw_next;
    logic [ANG_W-1:0]    other_reg, other_next;
    logic                zn_reg, zn_next;
    logic                zo_reg, zo_next;
    logic signed [31:0]  sum_new_reg, sum_new_next;
    logic signed [31:0]  sum_old_reg, sum_old_next;
    logic                neg_reg, neg_next;
    logic signed [COS_W-1:0] cos_new_reg, cos_new_next;
    logic signed [COS_W-1:0] cos_old_reg, cos_old_next;
    logic signed [COS_W:0]   dcos_reg, dcos_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic signed [47:0]  prod_reg, prod_next;
    logic signed [47:0]  ds_reg, ds_next;
    logic                acc_reg, acc_next;
    logic [ANG_W-1:0]    angle_reg, angle_next;
    logic signed [CS_W-1:0] csum_reg, csum_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic                    out_acc_reg, out_acc_next;
    logic [ANG_W-1:0]        out_angle_reg, out_angle_next;
    logic signed [CSUM_W-1:0] out_csum_reg, out_csum_next;

    // Angle store.
    logic [ANG_W-1:0]     mem [MAX_SITES];
    logic [MAX_SITES-1:0] valid_reg;
    logic [ANG_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ANG_W-1:0]     wr_data;
    logic [ANG_W-1:0]     rd_val;

    // Shared units.
    logic             sin_start;
    logic [T_W-1:0]   sin_t;
    sin_rsp_t         sin_rsp;
    logic             ln_start;
    logic [SIN_W-1:0] ln_v;
    ln_rsp_t          ln_rsp;

    logic               in_acc;
    logic               site_in_store;
    logic               site_in_use;
    logic signed [32:0] shift_prod;
    logic signed [32:0] shift_val;
    logic signed [31:0] csum_ext;

    emu_sin u_sin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sin_start),
        .t     (sin_t),
        .rsp   (sin_rsp)
    );

    emu_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ln_start),
        .v     (ln_v),
        .rsp   (ln_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign rd_val        = rd_valid_reg ? rd_data_reg : '0;
    assign site_in_store = (int'(site_reg) < MAX_SITES);
    assign site_in_use   = (int'(site_reg) < int'(n_reg));
    assign shift_prod    = 33'($signed(sf_reg)) * 33'($signed({1'b0, step_reg}));
    assign shift_val     = shift_prod >>> 15;
    assign csum_ext      = 32'(csum_reg);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg <= 14'd819;
            step_reg     <= 16'd10430;
            sites_reg    <= 7'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COUPLING:  coupling_reg <= cfg_data[CPL_W-1:0];
                CFG_STEP_SIZE: step_reg     <= cfg_data;
                CFG_SITES:     sites_reg    <= cfg_data[SC_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        site_next      = site_reg;
        load_next      = load_reg;
        sf_next        = sf_reg;
        draw_next      = draw_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        old_next       = old_reg;
        nw_next        = nw_reg;
        other_next     = other_reg;
        zn_next        = zn_reg;
        zo_next        = zo_reg;
        sum_new_next   = sum_new_reg;
        sum_old_next   = sum_old_reg;
        neg_next       = neg_reg;
        cos_new_next   = cos_new_reg;
        cos_old_next   = cos_old_reg;
        dcos_next      = dcos_reg;
        k_next         = k_reg;
        prod_next      = prod_reg;
        ds_next        = ds_reg;
        acc_next       = acc_reg;
        angle_next     = angle_reg;
        csum_next      = csum_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_acc_next   = out_acc_reg;
        out_angle_next = out_angle_reg;
        out_csum_next  = out_csum_reg;
        rd_en          = 1'b0;
        rd_addr        = ADDR_W'(idx_reg);
        wr_en          = 1'b0;
        wr_addr        = ADDR_W'(site_reg);
        wr_data        = nw_reg;
        sin_start      = 1'b0;
        sin_t          = pair_fold(old_reg, other_reg);
        ln_start       = 1'b0;
        ln_v           = sin_rsp.value;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = s_axis_tuser[0];
                    site_next = s_axis_tdata[5:0];
                    load_next = s_axis_tdata[21:6];
                    sf_next   = s_axis_tdata[37:22];
                    draw_next = s_axis_tdata[53:38];
                    n_next    = (int'(sites_reg) > MAX_SITES) ? CNT_W'(MAX_SITES)
                                                              : CNT_W'(sites_reg);
                    acc_next  = 1'b0;
                    state_next = (s_axis_tuser[0] == OP_LOAD) ? ST_LOAD : ST_OLD_RD;
                end
            end
            ST_LOAD:
            begin
                wr_en      = site_in_store;
                wr_data    = load_reg;
                angle_next = site_in_store ? load_reg : '0;
                idx_next   = '0;
                csum_next  = '0;
                state_next = ST_CS_RD;
            end
            ST_OLD_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(site_reg);
                state_next = ST_OLD_WAIT;
            end
            ST_OLD_WAIT:
            begin
                old_next     = rd_val;
                nw_next      = rd_val + shift_val[ANG_W-1:0];
                angle_next   = site_in_store ? rd_val : '0;
                idx_next     = '0;
                csum_next    = '0;
                zn_next      = 1'b0;
                zo_next      = 1'b0;
                sum_new_next = '0;
                sum_old_next = '0;
                state_next   = (site_in_store && site_in_use) ? ST_PR_RD : ST_CS_RD;
            end
            // Pair loop over the other angles in use.
            ST_PR_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = ST_PR_DONE;
                end
                else if (int'(idx_reg) == int'(site_reg))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_PR_GET;
                end
            end
            ST_PR_GET:
            begin
                other_next = rd_val;
                sin_start  = 1'b1;
                sin_t      = pair_fold(nw_reg, rd_val);
                state_next = ST_PN_SIN;
            end
            ST_PN_SIN:
            begin
                if (sin_rsp.done)
                begin
                    if (sin_rsp.value == '0)
                    begin
                        zn_next    = 1'b1;
                        state_next = ST_PO_START;
                    end
                    else
                    begin
                        ln_start   = 1'b1;
                        state_next = ST_PN_LN;
                    end
                end
            end
            ST_PN_LN:
            begin
                if (ln_rsp.done)
                begin
                    sum_new_next = sum_new_reg + 32'(ln_rsp.value);
                    state_next   = ST_PO_START;
                end
            end
            ST_PO_START:
            begin
                sin_start  = 1'b1;
                state_next = ST_PO_SIN;
            end
            ST_PO_SIN:
            begin
                if (sin_rsp.done)
                begin
                    if (sin_rsp.value == '0)
                    begin
                        zo_next    = 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_PR_RD;
                    end
                    else
                    begin
                        ln_start   = 1'b1;
                        state_next = ST_PO_LN;
                    end
                end
            end
            ST_PO_LN:
            begin
                if (ln_rsp.done)
                begin
                    sum_old_next = sum_old_reg + 32'(ln_rsp.value);
                    idx_next     = idx_reg + 1'b1;
                    state_next   = ST_PR_RD;
                end
            end
            // Coinciding angles decide at once; otherwise start the cosine change.
            ST_PR_DONE:
            begin
                if (zn_reg && zo_reg)
                begin
                    acc_next   = 1'b0;
                    state_next = ST_COMMIT;
                end
                else if (zn_reg)
                begin
                    acc_next   = (draw_reg == '0);
                    state_next = ST_COMMIT;
                end
                else if (zo_reg)
                begin
                    acc_next   = 1'b1;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    sin_start  = 1'b1;
                    sin_t      = cos_fold(nw_reg);
                    neg_next   = cos_neg(nw_reg);
                    state_next = ST_CN_SIN;
                end
            end
            ST_CN_SIN:
            begin
                if (sin_rsp.done)
                begin
                    cos_new_next = cos_round(sin_rsp.value, neg_reg);
                    sin_start    = 1'b1;
                    sin_t        = cos_fold(old_reg);
                    neg_next     = cos_neg(old_reg);
                    state_next   = ST_CO_SIN;
                end
            end
            ST_CO_SIN:
            begin
                if (sin_rsp.done)
                begin
                    cos_old_next = cos_round(sin_rsp.value, neg_reg);
                    state_next   = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                k_next     = K_W'(coupling_reg) * K_W'(n_reg);
                dcos_next  = (COS_W+1)'(cos_new_reg) - (COS_W+1)'(cos_old_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = $signed(48'(k_reg)) * 48'(dcos_reg);
                state_next = ST_DS;
            end
            ST_DS:
            begin
                ds_next = ((-prod_reg) >>> 12)
                          - ((48'(sum_new_reg) - 48'(sum_old_reg)) <<< 1);
                if (draw_reg == '0)
                begin
                    acc_next   = 1'b1;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    ln_start   = 1'b1;
                    ln_v       = {1'b0, draw_reg, 14'd0};
                    state_next = ST_ULN;
                end
            end
            ST_ULN:
            begin
                if (ln_rsp.done)
                begin
                    acc_next   = (48'(ln_rsp.value) <= -ds_reg);
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                wr_en      = acc_reg;
                angle_next = acc_reg ? nw_reg : old_reg;
                idx_next   = '0;
                csum_next  = '0;
                state_next = ST_CS_RD;
            end
            // Cosine sum over the angles in use.
            ST_CS_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CS_GET;
                end
            end
            ST_CS_GET:
            begin
                sin_start  = 1'b1;
                sin_t      = cos_fold(rd_val);
                neg_next   = cos_neg(rd_val);
                state_next = ST_CS_SIN;
            end
            ST_CS_SIN:
            begin
                if (sin_rsp.done)
                begin
                    csum_next  = csum_reg + CS_W'(cos_round(sin_rsp.value, neg_reg));
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CS_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_angle_next = angle_reg;
                    if (csum_ext > 32'sd8388607)
                    begin
                        out_csum_next = 24'h7FFFFF;
                    end
                    else if (csum_ext < -32'sd8388608)
                    begin
                        out_csum_next = 24'h800000;
                    end
                    else
                    begin
                        out_csum_next = csum_ext[CSUM_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        site_reg      <= site_next;
        load_reg      <= load_next;
        sf_reg        <= sf_next;
        draw_reg      <= draw_next;
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        old_reg       <= old_next;
        nw_reg        <= nw_next;
        other_reg     <= other_next;
        zn_reg        <= zn_next;
        zo_reg        <= zo_next;
        sum_new_reg   <= sum_new_next;
        sum_old_reg   <= sum_old_next;
        neg_reg       <= neg_next;
        cos_new_reg   <= cos_new_next;
        cos_old_reg   <= cos_old_next;
        dcos_reg      <= dcos_next;
        k_reg         <= k_next;
        prod_reg      <= prod_next;
        ds_reg        <= ds_next;
        acc_reg       <= acc_next;
        angle_reg     <= angle_next;
        csum_reg      <= csum_next;
        out_acc_reg   <= out_acc_next;
        out_angle_reg <= out_angle_next;
        out_csum_reg  <= out_csum_next;
    end

    // Angle store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_csum_reg, out_angle_reg, out_acc_reg};

    // The operation kind only steers the path out of idle.
    `EMU_ASSERT_IMP(a_load_path, state_reg == ST_LOAD, op_reg == OP_LOAD, "load state on an update")

    `EMU_ASSERT_NXT(a_busy_after_in, in_acc, !s_axis_tready, "input taken while an item is in work")

    `EMU_ASSERT_IMP(a_out_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "result without a finished item")

    `EMU_ASSERT_IMP(a_store_write, wr_en, state_reg == ST_LOAD || state_reg == ST_COMMIT, "store written outside load or commit")

endmodule
